/* sv/wsa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsa_pkg
// Shared types and constants for the windowed sample average block.
// ----------------------------------------------------------------------------
package wsa_pkg;

  localparam int IN_W  = 16;  // input sample width, two's complement
  localparam int SMP_W = 15;  // stored sample width (non-negative samples only)
  localparam int CNT_W = 5;   // window length, fill count and ring slot width
  localparam int SUM_W = 20;  // running sum width
  localparam int STS_W = 2;

  typedef enum logic [STS_W-1:0] {
    STATUS_OK  = 2'd0,
    STATUS_NEG = 2'd1,
    STATUS_OFF = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_UPDATE,
    ST_DIV,
    ST_HOLD
  } state_t;

endpackage

/* sv/wsa_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wsa_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 20,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/wsa_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsa_div
// Restoring divider: running sum over fill count, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module wsa_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [wsa_pkg::SUM_W-1:0] dividend,
  input  logic [wsa_pkg::CNT_W-1:0] divisor,
  output logic                      done,
  output logic [wsa_pkg::SUM_W-1:0] quotient
);
  import wsa_pkg::*;

  localparam int STEP_W = $clog2(SUM_W);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [SUM_W-1:0]  work;  // dividend bits shift out, quotient bits shift in
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  dvs;

  logic [CNT_W:0]    trial;
  logic              fits;
  logic [CNT_W:0]    trial_diff;

  always_comb begin
    trial      = {rem, work[SUM_W-1]};
    fits       = trial >= {1'b0, dvs};
    trial_diff = trial - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= busy && (step == STEP_W'(SUM_W - 1));
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(SUM_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      work <= {work[SUM_W-2:0], fits};
      rem  <= fits ? trial_diff[CNT_W-1:0] : trial[CNT_W-1:0];
    end
  end

  assign quotient = work;

endmodule

/* sv/windowed_sample_average.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_sample_average
// Moving average over a ring of the latest window_length samples.
// ----------------------------------------------------------------------------
// Sequence: a stored sample passes through LOAD, UPDATE and DIV; a rejected
//   sample while sampling is on skips LOAD; while off, it goes straight to HOLD.
// Intake: a new sample is taken only in IDLE, once the last result is loaded;
//   the bit-serial divider over the 20-bit sum sets the pace.
// Reset: synchronous, active high; clears window, fill count, slot and sum.
//   Ring contents are not cleared; an entry is read only after it is written.
// ----------------------------------------------------------------------------
module windowed_sample_average #(
  parameter int MAX_WINDOW = 20
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [wsa_pkg::CNT_W-1:0]  window_length,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [wsa_pkg::IN_W-1:0] sample_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [wsa_pkg::SMP_W-1:0]  average,
  output logic [wsa_pkg::CNT_W-1:0]  fill_count,
  output logic [wsa_pkg::STS_W-1:0]  status
);
  import wsa_pkg::*;

  localparam int ADDR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

  state_t           state, state_next;

  logic [CNT_W-1:0] win_len;
  logic [CNT_W-1:0] write_slot, write_slot_next;
  logic [CNT_W-1:0] held_count, held_count_next;
  logic [SUM_W-1:0] running_sum, running_sum_next;

  // item in flight
  logic [SMP_W-1:0] smp;
  logic [CNT_W-1:0] cur_slot;
  logic             full;
  logic             store;
  logic             use_div;
  status_t          sts;

  logic             avg_valid;
  logic [SMP_W-1:0] avg_out;
  logic [CNT_W-1:0] fill_out;
  status_t          status_out;

  logic             accept;
  logic             on;
  logic             negative;
  logic [CNT_W-1:0] slot_eff;
  logic             out_free;
  logic             load_out;
  logic             ram_we;
  logic             div_start;
  logic             div_done;
  logic [SUM_W-1:0] quotient;
  logic [SMP_W-1:0] rd_data;
  logic [CNT_W:0]   slot_inc;

  assign on       = (win_len >= CNT_W'(1)) && ({1'b0, win_len} <= (CNT_W+1)'(MAX_WINDOW));
  assign negative = sample_value[IN_W-1];
  assign accept   = in_valid && !in_stall;
  assign slot_eff = (write_slot >= win_len) ? '0 : write_slot;
  assign out_free = !avg_valid || !out_stall;

  wsa_ram #(
    .WIDTH (SMP_W),
    .DEPTH (MAX_WINDOW),
    .ADDR_W(ADDR_W)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ADDR_W'(cur_slot)),
    .wdata(smp),
    .raddr(ADDR_W'(cur_slot)),
    .rdata(rd_data)
  );

  wsa_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(running_sum_next),
    .divisor (held_count_next),
    .done    (div_done),
    .quotient(quotient)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          priority if (!on)     state_next = ST_HOLD;
          else if (negative)    state_next = ST_UPDATE;
          else                  state_next = ST_LOAD;
        end
      end
      ST_LOAD:   state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          state_next = out_free ? ST_IDLE : ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall  = 1'b1;
    ram_we    = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    unique case (state)
      ST_IDLE:   in_stall  = 1'b0;
      ST_LOAD:   ;
      ST_UPDATE: begin
        ram_we    = store;
        div_start = 1'b1;
      end
      ST_DIV:    load_out  = div_done && out_free;
      ST_HOLD:   load_out  = out_free;
      default:   ;
    endcase
  end

  // ring update; the sum and count feed the divider in the same cycle
  always_comb begin
    slot_inc         = {1'b0, cur_slot} + 1'b1;
    running_sum_next = running_sum;
    held_count_next  = held_count;
    write_slot_next  = write_slot;
    if (store) begin
      running_sum_next = running_sum + SUM_W'(smp)
                         - (full ? SUM_W'(rd_data) : SUM_W'(0));
      held_count_next  = full ? held_count : held_count + 1'b1;
      write_slot_next  = (slot_inc >= {1'b0, win_len}) ? '0 : slot_inc[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      win_len     <= '0;
      write_slot  <= '0;
      held_count  <= '0;
      running_sum <= '0;
      avg_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        win_len     <= window_length;
        write_slot  <= '0;
        held_count  <= '0;
        running_sum <= '0;
      end else if (state == ST_UPDATE) begin
        write_slot  <= write_slot_next;
        held_count  <= held_count_next;
        running_sum <= running_sum_next;
      end
      if (load_out) begin
        avg_valid <= 1'b1;
      end else if (!out_stall) begin
        avg_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      smp      <= sample_value[SMP_W-1:0];
      cur_slot <= slot_eff;
      full     <= held_count >= win_len;
      store    <= on && !negative;
      use_div  <= on;
      priority if (negative) sts <= STATUS_NEG;
      else if (!on)          sts <= STATUS_OFF;
      else                   sts <= STATUS_OK;
    end
    if (load_out) begin
      // empty window or sampling off reads as zero
      avg_out    <= (use_div && held_count != '0) ? quotient[SMP_W-1:0] : '0;
      fill_out   <= use_div ? held_count : '0;
      status_out <= sts;
    end
  end

  assign out_valid  = avg_valid;
  assign average    = avg_out;
  assign fill_count = fill_out;
  assign status     = status_out;

  a_held_le_window: assert property (@(posedge clk) disable iff (rst)
    held_count <= win_len)
    else $error("fill count exceeds window length");

  a_slot_in_window: assert property (@(posedge clk) disable iff (rst)
    held_count != '0 |-> write_slot < win_len)
    else $error("ring slot outside window");

  a_empty_sum_zero: assert property (@(posedge clk) disable iff (rst)
    held_count == '0 |-> running_sum == '0)
    else $error("running sum nonzero with empty window");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished outside divide state");

endmodule

/* dv/tb_windowed_sample_average.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_windowed_sample_average
// Drives signed samples through the moving-average block over a range of
// window settings, on, off and out of range. A running model of the ring,
// fill count and sum predicts each result, and the results are compared in
// order. Both handshakes idle at random in two of three modes; the third runs without idling.
// ----------------------------------------------------------------------------
module tb_windowed_sample_average;
  import wsa_pkg::*;

  localparam int MAX_WINDOW = 20;
  localparam int SAMPLE_TARGET = 750;

  typedef struct packed {
    logic [SMP_W-1:0] mean;
    logic [CNT_W-1:0] count;
    status_t          code;
  } avg_result_t;

  class average_tracker;
    logic [SMP_W-1:0] ring [MAX_WINDOW];
    logic [CNT_W-1:0] win;
    logic [CNT_W-1:0] slot;
    logic [CNT_W-1:0] held;
    logic [SUM_W-1:0] sum;
    avg_result_t      expected_results [$];
    int               errors;

    function new();
      win    = '0;
      slot   = '0;
      held   = '0;
      sum    = '0;
      errors = 0;
    endfunction

    function void set_window(logic [CNT_W-1:0] w);
      win  = w;
      slot = '0;
      held = '0;
      sum  = '0;
    endfunction

    function logic [SMP_W-1:0] window_mean();
      if (held == 0) return '0;
      return SMP_W'(sum / held);
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void note_sample(logic signed [IN_W-1:0] v);
      avg_result_t      r;
      logic [CNT_W-1:0] s;
      bit               on;
      on = (win >= 1) && (win <= MAX_WINDOW);
      if (v[IN_W-1]) begin
        // negative samples leave the ring untouched
        r.mean  = on ? window_mean() : '0;
        r.count = on ? held : '0;
        r.code  = STATUS_NEG;
      end else if (!on) begin
        r.mean  = '0;
        r.count = '0;
        r.code  = STATUS_OFF;
      end else begin
        s = slot;
        if (s >= win) s = '0;
        // full ring: drop the oldest sample from the sum
        if (held >= win) sum = sum - SUM_W'(ring[s]);
        else held = held + 1'b1;
        ring[s] = v[SMP_W-1:0];
        sum     = sum + SUM_W'(v[SMP_W-1:0]);
        slot    = (int'(s) + 1 >= int'(win)) ? '0 : s + 1'b1;
        r.mean  = window_mean();
        r.count = held;
        r.code  = STATUS_OK;
      end
      expected_results.push_back(r);
    endfunction

    function void check_result(logic [SMP_W-1:0] mean, logic [CNT_W-1:0] count,
                               logic [STS_W-1:0] code);
      avg_result_t e;
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: average %0d fill %0d status %0d",
                   mean, count, code);
        return;
      end
      e = expected_results.pop_front();
      if (mean !== e.mean || count !== e.count || code !== e.code) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected average %0d fill %0d status %0d, got %0d %0d %0d",
                   e.mean, e.count, e.code, mean, count, code);
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CNT_W-1:0]       window_length = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic signed [IN_W-1:0] sample_value = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [SMP_W-1:0]       average;
  logic [CNT_W-1:0]       fill_count;
  logic [STS_W-1:0]       status;

  average_tracker sb = new();
  int send_idle = 38;
  int recv_idle = 84;

  windowed_sample_average #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .window_length (window_length),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .sample_value  (sample_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .average       (average),
    .fill_count    (fill_count),
    .status        (status)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result(average, fill_count, status);
  end

  // Present one item and hold it until accepted. On return the valid is
  // either still high (caller sends again or lowers it in this step) or
  // already lowered for an idle gap.
  task automatic send_sample(input logic signed [IN_W-1:0] v);
    in_valid     <= 1'b1;
    sample_value <= v;
    do @(posedge clk); while (in_stall);
    sb.note_sample(v);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_window(input logic [CNT_W-1:0] w);
    drain_results();
    cfg_write     <= 1'b1;
    window_length <= w;
    @(posedge clk);
    sb.set_window(w);
    cfg_write <= 1'b0;
  endtask

  function automatic logic signed [IN_W-1:0] pick_sample();
    int r;
    r = $urandom_range(99);
    if (r < 10) return {1'b1, 15'($urandom)};
    if (r < 15) return 16'sh7FFF;
    if (r < 18) return '0;
    return {1'b0, 15'($urandom)};
  endfunction

  initial begin
    int                 sent;
    int                 r;
    int                 n;
    logic [CNT_W-1:0]   w;

    sent = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // window is off after reset
    send_sample(16'sd0);
    send_sample(16'sh8000);
    send_sample(16'sd5);
    send_sample(-16'sd1);

    write_window(5'd1);
    send_sample(16'sd32767);
    send_sample(16'sd32767);
    send_sample(16'sd0);
    send_sample(-16'sd1);

    // fill a small ring, then wrap over the oldest entries
    write_window(5'd3);
    send_sample(16'sd32767);
    send_sample(16'sd0);
    send_sample(16'sd100);
    send_sample(16'sd7);
    send_sample(16'sd32767);
    send_sample(-16'sd5);

    // rewriting the same window still clears the ring
    write_window(5'd3);
    send_sample(16'sd9);

    // lengths above the maximum act as off
    write_window(5'd31);
    send_sample(16'sd10);
    send_sample(-16'sd2);
    write_window(5'd21);
    send_sample(16'sd1);

    while (sent < SAMPLE_TARGET) begin
      if (sent < SAMPLE_TARGET / 3) begin
        send_idle = 38;
        recv_idle = 84;
      end else if (sent < 2 * SAMPLE_TARGET / 3) begin
        send_idle = 84;
        recv_idle = 38;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      r = $urandom_range(99);
      if (r < 8)       w = '0;
      else if (r < 14) w = CNT_W'($urandom_range(MAX_WINDOW + 1, 31));
      else if (r < 30) w = CNT_W'(MAX_WINDOW);
      else if (r < 40) w = 5'd1;
      else             w = CNT_W'($urandom_range(2, MAX_WINDOW - 1));
      write_window(w);
      n = $urandom_range(10, 50);
      repeat (n) send_sample(pick_sample());
      sent += n;
    end

    drain_results();
    repeat (30) @(posedge clk);
    if (sb.errors == 0)
      $display("PASS windowed_sample_average");
    else
      $display("FAIL windowed_sample_average");
    $finish;
  end

  initial begin
    #(10_000_000);
    $display("FAIL windowed_sample_average");
    $finish;
  end

endmodule
